>>> rtl/core/lancup_pkg.sv
// Shared types and constants of the Lanczos-2 upscaler: field widths, the
// per-phase weight table and divisor constants, and the job record.
// No dependencies.
package lancup_pkg;

	localparam int LOBES     = 2;
	localparam int WIN       = 2 * LOBES;
	localparam int TAPS      = WIN * WIN;
	localparam int PHASES    = 4;
	localparam int PIX_W     = 8;
	localparam int WT_W      = 16;
	localparam int COL_W     = 12;
	localparam int ROW_W     = 12;
	localparam int OUT_COL_W = 11;
	localparam int OUT_ROW_W = 13;
	localparam int WCFG_W    = 11;
	localparam int HCFG_W    = 13;
	localparam int CFG_W     = 13;
	localparam int QDEPTH    = 2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [HCFG_W-1:0] MIN_SIZE   = 13'd3;
	localparam logic [HCFG_W-1:0] MAX_HEIGHT = 13'd4096;

	// Kernel products scaled by 4096 and truncated toward zero, [phase*16 + row*4 + col].
	localparam logic signed [WT_W-1:0] WEIGHT_ROM [PHASES*TAPS] = '{
		16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0,
		16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd260, 16'sd2347, 16'sd2347, -16'sd260,
		16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
		16'sd0, -16'sd260, 16'sd0, 16'sd0, 16'sd0, 16'sd2347, 16'sd0, 16'sd0,
		16'sd0, 16'sd2347, 16'sd0, 16'sd0, 16'sd0, -16'sd260, 16'sd0, 16'sd0,
		16'sd16, -16'sd149, -16'sd149, 16'sd16, -16'sd149, 16'sd1345, 16'sd1345, -16'sd149,
		-16'sd149, 16'sd1345, 16'sd1345, -16'sd149, 16'sd16, -16'sd149, -16'sd149, 16'sd16
	};

	// Weight sum of each phase, floor(2^32 / sum), and 256 * sum (saturation point).
	localparam logic [12:0] PHASE_DIV   [PHASES] = '{13'd4096, 13'd4174, 13'd4174, 13'd4252};
	localparam logic [20:0] PHASE_RECIP [PHASES] =
		'{21'd1048576, 21'd1028981, 21'd1028981, 21'd1010105};
	localparam logic [21:0] PHASE_LIMIT [PHASES] =
		'{22'd1048576, 22'd1068544, 22'd1068544, 22'd1088512};

	typedef struct packed {
		logic [TAPS-1:0][PIX_W-1:0] win;
		logic [COL_W-1:0]           c;
		logic [COL_W-1:0]           w_m1;
		logic [ROW_W-1:0]           r;
		logic [ROW_W-1:0]           h_m1;
		logic [1:0]                 xspan;
		logic [1:0]                 yspan;
	} job_t;

endpackage

>>> rtl/core/lancup_front.sv
// Front end of the upscaler: configuration registers, frame counters, the
// three-line row store and the 4x4 window; emits one job per window.
// Depends on lancup_pkg.
module lancup_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [lancup_pkg::CFG_W-1:0] cfg_data,
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  logic [lancup_pkg::PIX_W-1:0] pixel_value,
	input  logic                        q_full,
	output logic                        push,
	output lancup_pkg::job_t            push_job
);
	import lancup_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic F_IDLE   = 1'b0;
	localparam logic F_UPDATE = 1'b1;

	logic [WCFG_W-1:0] width_q;
	logic [HCFG_W-1:0] height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              fstate_q;
	logic [PIX_W-1:0]  pix_q;
	logic [COL_W-1:0]  c_q;
	logic [ROW_W-1:0]  r_q;
	logic [3*PIX_W-1:0] rd_q;
	logic [TAPS-1:0][PIX_W-1:0] win_q;
	logic [TAPS-1:0][PIX_W-1:0] win_next;
	logic [3*PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [HCFG_W-1:0] w_wide;
	logic [HCFG_W-1:0] w_sat;
	logic [HCFG_W-1:0] h_sat;
	logic [COL_W-1:0]  w_m1;
	logic [ROW_W-1:0]  h_m1;
	logic [COL_W-1:0]  c_cur;
	logic [ROW_W-1:0]  r_cur;
	logic [WIN-1:0][PIX_W-1:0] colv;
	logic              accept;

	assign w_wide = {2'b00, width_q};

	always_comb begin
		priority if (w_wide < MIN_SIZE) begin
			w_sat = MIN_SIZE;
		end else if (w_wide > HCFG_W'(MAX_WIDTH)) begin
			w_sat = HCFG_W'(MAX_WIDTH);
		end else begin
			w_sat = w_wide;
		end
		priority if (height_q < MIN_SIZE) begin
			h_sat = MIN_SIZE;
		end else if (height_q > MAX_HEIGHT) begin
			h_sat = MAX_HEIGHT;
		end else begin
			h_sat = height_q;
		end
	end

	assign w_m1  = COL_W'(w_sat - 13'd1);
	assign h_m1  = ROW_W'(h_sat - 13'd1);
	assign c_cur = (col_q > w_m1) ? '0 : col_q;
	assign r_cur = (row_q > h_m1) ? '0 : row_q;

	assign pixel_stall = (fstate_q == F_UPDATE) || q_full;
	assign accept      = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WCFG_W'(640);
			height_q <= HCFG_W'(480);
			col_q    <= '0;
			row_q    <= '0;
			fstate_q <= F_IDLE;
			win_q    <= '0;
		end else begin
			priority if (cfg_write) begin
				if (cfg_index == REG_WIDTH) begin
					width_q <= cfg_data[WCFG_W-1:0];
				end else begin
					height_q <= cfg_data;
				end
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (c_cur == w_m1) begin
					col_q <= '0;
					row_q <= (r_cur == h_m1) ? '0 : r_cur + 1'b1;
				end else begin
					col_q <= c_cur + 1'b1;
					row_q <= r_cur;
				end
			end
			if (accept) begin
				fstate_q <= F_UPDATE;
			end else if (fstate_q == F_UPDATE) begin
				fstate_q <= F_IDLE;
				win_q    <= win_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel_value;
			c_q   <= c_cur;
			r_q   <= r_cur;
			rd_q  <= line_mem[c_cur[AW-1:0]];
		end
		if (fstate_q == F_UPDATE) begin
			line_mem[c_q[AW-1:0]] <= {pix_q, rd_q[3*PIX_W-1:PIX_W]};
		end
	end

	assign colv = {pix_q, rd_q};

	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			for (int j = 0; j < WIN - 1; j++) begin
				win_next[k*WIN+j] = win_q[k*WIN+j+1];
			end
			win_next[k*WIN+WIN-1] = colv[k];
		end
	end

	assign push = (fstate_q == F_UPDATE) && (c_q >= COL_W'(LOBES)) && (r_q >= ROW_W'(LOBES));

	always_comb begin
		push_job.win   = win_next;
		push_job.c     = c_q;
		push_job.w_m1  = w_m1;
		push_job.r     = r_q;
		push_job.h_m1  = h_m1;
		push_job.xspan = (c_q == w_m1) ? 2'(LOBES) : 2'd0;
		push_job.yspan = (r_q == h_m1) ? 2'(LOBES) : 2'd0;
	end

endmodule

>>> rtl/core/lancup_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on lancup_pkg.
module lancup_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lancup_pkg::job_t push_job,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output lancup_pkg::job_t head_job
);
	import lancup_pkg::*;

	job_t       mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'(QDEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("job popped from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

>>> rtl/core/lancup_back.sv
// Back end of the upscaler: walks the centers and phases of the head job and
// runs each output through tap select, multiply, sums and constant division.
// Depends on lancup_pkg.
module lancup_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  lancup_pkg::job_t                head_job,
	output logic                            pop,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [lancup_pkg::OUT_COL_W-1:0] out_col,
	output logic [lancup_pkg::OUT_ROW_W-1:0] out_row,
	output logic [lancup_pkg::PIX_W-1:0]     out_value,
	output logic                            run_last
);
	import lancup_pkg::*;

	localparam int PROD_W = PIX_W + 1 + WT_W;
	localparam int ACC_W  = 23;
	localparam int POS_W  = 21;
	localparam int Q_W    = 9;

	logic       adv;
	logic       issue;
	logic       last_pt;
	logic [1:0] ox_q, oy_q;
	logic       px_q, py_q;
	logic [COL_W-1:0] cx;
	logic [ROW_W-1:0] cy;
	logic [COL_W:0]   xt [WIN];
	logic [ROW_W:0]   yt [WIN];
	logic [COL_W-1:0] xsel [WIN];
	logic [ROW_W-1:0] ysel [WIN];
	logic [1:0]       wc [WIN];
	logic [1:0]       wr [WIN];
	logic [TAPS-1:0][PIX_W-1:0] pix_sel;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [1:0] ph_s1, ph_s2, ph_s3, ph_s4, ph_s5, ph_s6;
	logic [OUT_COL_W-1:0] col_s1, col_s2, col_s3, col_s4, col_s5, col_s6;
	logic [OUT_ROW_W-1:0] row_s1, row_s2, row_s3, row_s4, row_s5, row_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [TAPS-1:0][PIX_W-1:0] pix_s1;
	logic signed [PROD_W-1:0] prod_s2 [TAPS];
	logic signed [ACC_W-1:0]  rsum_s3 [WIN];
	logic signed [ACC_W-1:0]  acc_s4;
	logic neg_s5, neg_s6, big_s5, big_s6;
	logic [POS_W-1:0] acc_s5, acc_s6;
	logic [Q_W-1:0]   q0_s5, q0_s6;
	logic [2*POS_W-1:0] ratio;
	logic [Q_W+13-1:0]  qd_s6;
	logic [Q_W+13-1:0]  rem;
	logic [Q_W-1:0]     quo;

	logic                 res_valid_q;
	logic [OUT_COL_W-1:0] res_col_q;
	logic [OUT_ROW_W-1:0] res_row_q;
	logic [PIX_W-1:0]     res_value_q;
	logic                 res_last_q;

	assign adv     = !(res_valid_q && result_stall);
	assign issue   = adv && head_valid;
	assign last_pt = (ox_q == head_job.xspan) && (oy_q == head_job.yspan) && px_q && py_q;
	assign pop     = issue && last_pt;

	assign cx = head_job.c - COL_W'(LOBES) + COL_W'(ox_q);
	assign cy = head_job.r - ROW_W'(LOBES) + ROW_W'(oy_q);

	// Walk px, then py, then the center column, then the center row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			px_q <= 1'b0;
			py_q <= 1'b0;
		end else if (issue) begin
			px_q <= ~px_q;
			if (px_q) begin
				py_q <= ~py_q;
				if (py_q) begin
					if (ox_q == head_job.xspan) begin
						ox_q <= '0;
						oy_q <= last_pt ? 2'd0 : oy_q + 2'd1;
					end else begin
						ox_q <= ox_q + 2'd1;
					end
				end
			end
		end
	end

	// Clamped tap coordinates and their place in the window.
	always_comb begin
		for (int t = 0; t < WIN; t++) begin
			xt[t] = {1'b0, cx} + (COL_W+1)'(t);
			yt[t] = {1'b0, cy} + (ROW_W+1)'(t);
			if (xt[t] == '0) begin
				xsel[t] = '0;
			end else if (xt[t] - 1'b1 > {1'b0, head_job.w_m1}) begin
				xsel[t] = head_job.w_m1;
			end else begin
				xsel[t] = COL_W'(xt[t] - 1'b1);
			end
			if (yt[t] == '0) begin
				ysel[t] = '0;
			end else if (yt[t] - 1'b1 > {1'b0, head_job.h_m1}) begin
				ysel[t] = head_job.h_m1;
			end else begin
				ysel[t] = ROW_W'(yt[t] - 1'b1);
			end
			wc[t] = 2'(xsel[t] - head_job.c + COL_W'(WIN - 1));
			wr[t] = 2'(ysel[t] - head_job.r + ROW_W'(WIN - 1));
		end
		for (int tr = 0; tr < WIN; tr++) begin
			for (int tc = 0; tc < WIN; tc++) begin
				pix_sel[tr*WIN+tc] = head_job.win[{wr[tr], wc[tc]}];
			end
		end
	end

	assign ratio = acc_s4[POS_W-1:0] * PHASE_RECIP[ph_s4];
	assign rem   = {1'b0, acc_s6} - qd_s6;
	assign quo   = q0_s6 + Q_W'(rem >= (Q_W+13)'(PHASE_DIV[ph_s6]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			res_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1  <= pix_sel;
			ph_s1   <= {py_q, px_q};
			col_s1  <= OUT_COL_W'({cx, px_q});
			row_s1  <= OUT_ROW_W'({cy, py_q});
			last_s1 <= last_pt;

			for (int t = 0; t < TAPS; t++) begin
				prod_s2[t] <= $signed({1'b0, pix_s1[t]}) * WEIGHT_ROM[{ph_s1, 4'(t)}];
			end
			{ph_s2, col_s2, row_s2, last_s2} <= {ph_s1, col_s1, row_s1, last_s1};

			for (int k = 0; k < WIN; k++) begin
				rsum_s3[k] <= ACC_W'(prod_s2[k*WIN]) + ACC_W'(prod_s2[k*WIN+1])
					+ ACC_W'(prod_s2[k*WIN+2]) + ACC_W'(prod_s2[k*WIN+3]);
			end
			{ph_s3, col_s3, row_s3, last_s3} <= {ph_s2, col_s2, row_s2, last_s2};

			acc_s4 <= rsum_s3[0] + rsum_s3[1] + rsum_s3[2] + rsum_s3[3];
			{ph_s4, col_s4, row_s4, last_s4} <= {ph_s3, col_s3, row_s3, last_s3};

			neg_s5 <= (acc_s4 <= 0);
			big_s5 <= (acc_s4 >= $signed({1'b0, PHASE_LIMIT[ph_s4]}));
			acc_s5 <= acc_s4[POS_W-1:0];
			q0_s5  <= ratio[32 +: Q_W];
			{ph_s5, col_s5, row_s5, last_s5} <= {ph_s4, col_s4, row_s4, last_s4};

			qd_s6  <= q0_s5 * PHASE_DIV[ph_s5];
			q0_s6  <= q0_s5;
			acc_s6 <= acc_s5;
			neg_s6 <= neg_s5;
			big_s6 <= big_s5;
			{ph_s6, col_s6, row_s6, last_s6} <= {ph_s5, col_s5, row_s5, last_s5};

			res_col_q  <= col_s6;
			res_row_q  <= row_s6;
			res_last_q <= last_s6;
			priority if (neg_s6) begin
				res_value_q <= '0;
			end else if (big_s6) begin
				res_value_q <= 8'd255;
			end else begin
				res_value_q <= quo[PIX_W-1:0];
			end
		end
	end

	assign result_valid = res_valid_q;
	assign out_col      = res_col_q;
	assign out_row      = res_row_q;
	assign out_value    = res_value_q;
	assign run_last     = res_last_q;

endmodule

>>> rtl/core/lanczos_integer_upscaler_unit.sv
// Lanczos-2 upscaler, scale 2: the front end stalls after each pixel while it
// shifts the window; the back end produces one result per cycle while a job is
// queued and no stall holds it, four per center, four per typical pixel,
// up to 36 at the last column and row. Reset clears counters, window, queue
// and pipeline valids at once; the row store is not cleared and needs no pass.
module lanczos_integer_upscaler_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic                             cfg_index,
	input  logic [lancup_pkg::CFG_W-1:0]     cfg_data,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  logic [lancup_pkg::PIX_W-1:0]     pixel_value,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [lancup_pkg::OUT_COL_W-1:0] out_col,
	output logic [lancup_pkg::OUT_ROW_W-1:0] out_row,
	output logic [lancup_pkg::PIX_W-1:0]     out_value,
	output logic                             run_last
);
	import lancup_pkg::*;

	// Jobs carry a snapshot of the window, so the front end keeps shifting
	// pixels in while the back end still works on earlier centers.
	logic push;
	logic q_full;
	logic pop;
	logic head_valid;
	job_t push_job;
	job_t head_job;

	// Front end: row store read in the accept cycle, write-back and window
	// shift in the next one.
	lancup_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_value (pixel_value),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	// Two jobs of slack let the back end drain while new pixels arrive.
	lancup_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back end: a stall-all pipeline ending in the output register, which
	// holds a result steady while the receiver stalls.
	lancup_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_col      (out_col),
		.out_row      (out_row),
		.out_value    (out_value),
		.run_last     (run_last)
	);

endmodule

>>> verif/upscale_checker.sv
// Checker of the Lanczos-2 upscaler: it follows register writes and accepted pixels,
// predicts every upscaled pixel and compares the results as they leave the block.
// Depends on lancup_pkg for register indexes and port widths.
module upscale_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic                             cfg_index,
	input  logic [lancup_pkg::CFG_W-1:0]     cfg_data,
	input  logic                             pixel_valid,
	input  logic                             pixel_stall,
	input  logic [lancup_pkg::PIX_W-1:0]     pixel_value,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  logic [lancup_pkg::OUT_COL_W-1:0] out_col,
	input  logic [lancup_pkg::OUT_ROW_W-1:0] out_row,
	input  logic [lancup_pkg::PIX_W-1:0]     out_value,
	input  logic                             run_last,
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE = 1024;

	typedef struct {
		logic [lancup_pkg::OUT_COL_W-1:0] col;
		logic [lancup_pkg::OUT_ROW_W-1:0] row;
		logic [lancup_pkg::PIX_W-1:0]     value;
		logic                             last;
	} upscaled_t;

	// Kernel products times 4096, per phase (py*2+px), row tap major.
	localparam int KERNEL [64] = '{
		0, 0, 0, 0, 0, 4096, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, -260, 2347, 2347, -260, 0, 0, 0, 0, 0, 0, 0, 0,
		0, -260, 0, 0, 0, 2347, 0, 0, 0, 2347, 0, 0, 0, -260, 0, 0,
		16, -149, -149, 16, -149, 1345, 1345, -149,
		-149, 1345, 1345, -149, 16, -149, -149, 16
	};

	upscaled_t   upscaled_q[$];
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	logic [7:0]  line_mem [3*LINE];
	logic [7:0]  window [16];
	int          col_pos;
	int          row_pos;

	assign pending = upscaled_q.size();

	function automatic int fit_size(int v, int hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int clip(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic logic [7:0] filter_value(int cx, int cy, int c, int r, int w, int h,
			int phase);
		longint acc;
		longint wsum;
		int y;
		int x;
		int wt;
		acc = 0;
		wsum = 0;
		for (int tr = 0; tr < 4; tr++) begin
			y = clip(cy + tr - 1, 0, h - 1);
			for (int tc = 0; tc < 4; tc++) begin
				x = clip(cx + tc - 1, 0, w - 1);
				wt = KERNEL[phase*16 + tr*4 + tc];
				acc += longint'(window[((y - r + 3)*4 + (x - c + 3)) & 15]) * wt;
				wsum += wt;
			end
		end
		if (wsum <= 0) return 8'd0;
		return 8'(clip(int'(acc / wsum), 0, 255));
	endfunction

	task automatic absorb_pixel(input logic [7:0] pix);
		int w;
		int h;
		int c;
		int r;
		int cx_hi;
		int cy_hi;
		int n;
		logic [7:0] colv [4];
		upscaled_t u;
		w = fit_size(width_reg, LINE);
		h = fit_size(height_reg, 4096);
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;
		colv[0] = line_mem[c];
		colv[1] = line_mem[LINE + c];
		colv[2] = line_mem[2*LINE + c];
		colv[3] = pix;
		line_mem[c] = colv[1];
		line_mem[LINE + c] = colv[2];
		line_mem[2*LINE + c] = pix;
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 3; j++)
				window[k*4 + j] = window[k*4 + j + 1];
			window[k*4 + 3] = colv[k];
		end
		n = 0;
		if (c >= 2 && r >= 2) begin
			// The last column and the last row flush the trailing centers too.
			cx_hi = (c == w - 1) ? c : c - 2;
			cy_hi = (r == h - 1) ? r : r - 2;
			for (int cy = r - 2; cy <= cy_hi; cy++)
				for (int cx = c - 2; cx <= cx_hi; cx++)
					for (int py = 0; py < 2; py++)
						for (int px = 0; px < 2; px++) begin
							u.col = 11'(cx*2 + px);
							u.row = 13'(cy*2 + py);
							u.value = filter_value(cx, cy, c, r, w, h, py*2 + px);
							u.last = 1'b0;
							upscaled_q.push_back(u);
							n++;
						end
			if (n > 0) begin
				u = upscaled_q.pop_back();
				u.last = 1'b1;
				upscaled_q.push_back(u);
			end
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		upscaled_t e;
		if (!arst_n) begin
			width_reg = 11'd640;
			height_reg = 13'd480;
			foreach (line_mem[i]) line_mem[i] = 8'd0;
			foreach (window[i]) window[i] = 8'd0;
			col_pos = 0;
			row_pos = 0;
			fail_count = 0;
			upscaled_q.delete();
		end else begin
			if (cfg_write) begin
				if (cfg_index == lancup_pkg::REG_WIDTH)
					width_reg = cfg_data[10:0];
				else
					height_reg = cfg_data[12:0];
				col_pos = 0;
				row_pos = 0;
			end
			if (pixel_valid && !pixel_stall)
				absorb_pixel(pixel_value);
			if (result_valid && !result_stall) begin
				if (upscaled_q.size() == 0) begin
					$display("%0t: unexpected result col %0d row %0d value %0d last %0b",
						$realtime, out_col, out_row, out_value, run_last);
					fail_count++;
				end else begin
					e = upscaled_q.pop_front();
					if (e.col !== out_col || e.row !== out_row || e.value !== out_value ||
							e.last !== run_last) begin
						$display("%0t: expected col %0d row %0d value %0d last %0b, got col %0d row %0d value %0d last %0b",
							$realtime, e.col, e.row, e.value, e.last,
							out_col, out_row, out_value, run_last);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

>>> verif/lanczos_integer_upscaler_unit_test.sv
// Top of the upscaler testbench: clock, reset, register writes, pixel requests and
// random result stalls; the verdict comes from upscale_checker's failure count.
// Depends on lancup_pkg, upscale_checker and lanczos_integer_upscaler_unit.
module lanczos_integer_upscaler_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 4000;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_write;
	logic                             cfg_index;
	logic [lancup_pkg::CFG_W-1:0]     cfg_data;
	logic                             pixel_valid;
	logic                             pixel_stall;
	logic [lancup_pkg::PIX_W-1:0]     pixel_value;
	logic                             result_valid;
	logic                             result_stall;
	logic [lancup_pkg::OUT_COL_W-1:0] out_col;
	logic [lancup_pkg::OUT_ROW_W-1:0] out_row;
	logic [lancup_pkg::PIX_W-1:0]     out_value;
	logic                             run_last;
	int                               fail_count;
	int                               pending;

	// When steady is set, neither side idles, so back-to-back stretches occur too.
	logic steady;
	int   stall_hold;
	int   idle_cycles;
	int   random_sent;

	lanczos_integer_upscaler_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel_value(pixel_value),
		.result_valid(result_valid), .result_stall(result_stall),
		.out_col(out_col), .out_row(out_row), .out_value(out_value), .run_last(run_last)
	);

	upscale_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel_value(pixel_value),
		.result_valid(result_valid), .result_stall(result_stall),
		.out_col(out_col), .out_row(out_row), .out_value(out_value), .run_last(run_last),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The receiving side holds each stall decision for a random stretch.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			if (steady) begin
				result_stall <= 1'b0;
				stall_hold <= 16;
			end else begin
				result_stall <= ($urandom_range(0, 2) == 0);
				stall_hold <= gap_length();
			end
		end else begin
			stall_hold <= stall_hold - 1;
		end
	end

	// The watchdog counts cycles in which neither channel moves anything.
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// One pixel request. A gap lowers valid first; otherwise valid stays high and only
	// the value changes, so valid gets one assignment per step.
	task automatic send_pixel(input logic [7:0] v);
		int gap;
		gap = steady ? 0 : gap_length();
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (pixel_stall);
	endtask

	// Registers are only written once the block has drained. A pixel that yields
	// nothing may still be in flight, so a pause follows before the write.
	task automatic write_reg(input logic idx, input logic [12:0] data);
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Pattern 0 is random data, 1 alternates black and white, 2 is mostly extremes.
	task automatic send_frame(input int count, input int pattern);
		logic [7:0] v;
		for (int i = 0; i < count; i++) begin
			case (pattern)
				0: begin
					v = $urandom_range(0, 255);
				end
				1: begin
					v = (i % 2 == 0) ? 8'hFF : 8'h00;
				end
				default: begin
					v = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h00;
					if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 255);
				end
			endcase
			send_pixel(v);
		end
	endtask

	initial begin
		int w;
		int h;
		int count;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = lancup_pkg::REG_WIDTH;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel_value = '0;
		result_stall = 1'b0;
		stall_hold = 0;
		idle_cycles = 0;
		steady = 1'b0;
		random_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size of 640 by 480: a few pixels, not enough for any result.
		send_frame(4, 1);

		// Smallest frame, black and white, twice so that the frame wraps around.
		write_reg(lancup_pkg::REG_WIDTH, 13'd3);
		write_reg(lancup_pkg::REG_HEIGHT, 13'd3);
		send_frame(18, 1);

		// Sizes below the minimum saturate to three.
		write_reg(lancup_pkg::REG_WIDTH, 13'd0);
		write_reg(lancup_pkg::REG_HEIGHT, 13'd2);
		steady = 1'b1;
		send_frame(9, 2);
		steady = 1'b0;

		// Widest frame: all ones in the data saturates the width to its maximum, so
		// the first row stays open and no result may appear.
		write_reg(lancup_pkg::REG_WIDTH, 13'h1FFF);
		write_reg(lancup_pkg::REG_HEIGHT, 13'd3);
		send_frame(100, 0);

		// Tallest frame: the largest height value saturates to 4096 rows, so the
		// first thirty rows run without a bottom edge.
		write_reg(lancup_pkg::REG_WIDTH, 13'd3);
		write_reg(lancup_pkg::REG_HEIGHT, 13'h1FFF);
		steady = 1'b1;
		send_frame(3 * 30, 0);
		steady = 1'b0;

		// Random small frames: most are whole frames, some end early so that the
		// next write restarts a frame in the middle.
		while (random_sent < 130) begin
			w = $urandom_range(3, 10);
			h = $urandom_range(3, 7);
			if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 2);
			write_reg(lancup_pkg::REG_WIDTH, 13'(w));
			write_reg(lancup_pkg::REG_HEIGHT, 13'(h));
			if (w < 3) w = 3;
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 7)
				count = w * h * $urandom_range(1, 2);
			else
				count = $urandom_range(1, w * h);
			send_frame(count, ($urandom_range(0, 4) == 0) ? 2 : 0);
			random_sent += count;
		end
		steady = 1'b0;
		pixel_valid <= 1'b0;

		// Drain; the watchdog bounds this wait.
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/lancup_pkg.sv
rtl/core/lancup_front.sv
rtl/core/lancup_queue.sv
rtl/core/lancup_back.sv
rtl/core/lanczos_integer_upscaler_unit.sv
verif/upscale_checker.sv
verif/lanczos_integer_upscaler_unit_test.sv
